// File: design/itar_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itar_pkg: shared types and constants for the integer to ASCII converter
// Payload structs, queue sizes, divider sizing and the digit to ASCII map.
// ----------------------------------------------------------------------------
package itar_pkg;

	localparam int VALUE_WIDTH = 32;
	localparam int RADIX_W     = 6;
	localparam int CHAR_W      = 7;
	localparam int REM_W       = RADIX_W + 1;

	localparam logic [RADIX_W-1:0] MIN_RADIX = RADIX_W'(2);
	localparam logic [RADIX_W-1:0] MAX_RADIX = RADIX_W'(36);

	localparam logic [CHAR_W-1:0] DECIMAL_LIMIT = CHAR_W'(10);
	localparam logic [CHAR_W-1:0] CH_ZERO       = CHAR_W'(48);
	localparam logic [CHAR_W-1:0] CH_UPPER_A    = CHAR_W'(65);
	localparam logic [CHAR_W-1:0] CH_MINUS      = CHAR_W'(45);

	// Digit store addressing and digit count
	localparam int ADDR_W = $clog2(VALUE_WIDTH);
	localparam int CNT_W  = $clog2(VALUE_WIDTH + 1);

	// Divider: quotient bits resolved per cycle, cycles per digit
	localparam int DIV_BITS   = 8;
	localparam int DIV_CYCLES = (VALUE_WIDTH + DIV_BITS - 1) / DIV_BITS;
	localparam int PAD_W      = DIV_CYCLES * DIV_BITS;
	localparam int STEP_W     = (DIV_CYCLES > 1) ? $clog2(DIV_CYCLES) : 1;

	// Queue between front and back, and the result queue (powers of two)
	localparam int FQ_DEPTH = 2;
	localparam int FQ_PTR_W = $clog2(FQ_DEPTH);
	localparam int FQ_CNT_W = $clog2(FQ_DEPTH + 1);
	localparam int OQ_DEPTH = 4;
	localparam int OQ_PTR_W = $clog2(OQ_DEPTH);
	localparam int OQ_CNT_W = $clog2(OQ_DEPTH + 1);

	typedef struct packed {
		logic signed [VALUE_WIDTH-1:0] value;
		logic [RADIX_W-1:0]            radix;
	} in_item_t;

	typedef struct packed {
		logic [CHAR_W-1:0] character;
		logic              last;
	} out_item_t;

	typedef struct packed {
		logic [VALUE_WIDTH-1:0] magnitude;
		logic [RADIX_W-1:0]     radix;
		logic                   negative;
	} work_t;

	function automatic logic [CHAR_W-1:0] digit_ascii(input logic [RADIX_W-1:0] d);
		logic [CHAR_W-1:0] d7;
		d7 = CHAR_W'(d);
		if (d7 < DECIMAL_LIMIT) begin
			return CH_ZERO + d7;
		end
		return CH_UPPER_A + d7 - DECIMAL_LIMIT;
	endfunction

endpackage

// File: design/itar_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itar_front: input side of the converter
// Clamps the radix, splits sign and magnitude, and queues the work items.
// ----------------------------------------------------------------------------
module itar_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	output logic               full,
	input  itar_pkg::in_item_t request,
	output logic               work_vld,
	input  logic               work_rdy,
	output itar_pkg::work_t    work
);

	itar_pkg::work_t                    entry_q [itar_pkg::FQ_DEPTH];
	itar_pkg::work_t                    classified;
	logic [itar_pkg::FQ_PTR_W-1:0]      wr_ptr_q;
	logic [itar_pkg::FQ_PTR_W-1:0]      rd_ptr_q;
	logic [itar_pkg::FQ_CNT_W-1:0]      count_q;
	logic [itar_pkg::VALUE_WIDTH-1:0]   raw;
	logic                               wr;
	logic                               rd;

	// Classify: sign, unsigned magnitude, clamped radix
	always_comb begin
		raw                 = request.value;
		classified.negative = raw[itar_pkg::VALUE_WIDTH-1];
		classified.magnitude = classified.negative ? (~raw + 1'b1) : raw;
		if (request.radix inside {[0:1]}) begin
			classified.radix = itar_pkg::MIN_RADIX;
		end else if (request.radix > itar_pkg::MAX_RADIX) begin
			classified.radix = itar_pkg::MAX_RADIX;
		end else begin
			classified.radix = request.radix;
		end
	end

	assign full     = (count_q == itar_pkg::FQ_CNT_W'(itar_pkg::FQ_DEPTH));
	assign work_vld = (count_q != '0);
	assign work     = entry_q[rd_ptr_q];
	assign wr       = push && !full;
	assign rd       = work_vld && work_rdy;

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= classified;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_front_count: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= itar_pkg::FQ_CNT_W'(itar_pkg::FQ_DEPTH))
		else $error("front queue over-filled");
`endif

endmodule

// File: design/itar_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itar_back: digit generation and character issue
// Divides the magnitude by the radix, stores digits, then issues the text.
// ----------------------------------------------------------------------------
module itar_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          work_vld,
	output logic                          work_rdy,
	input  itar_pkg::work_t               work,
	input  logic [itar_pkg::OQ_CNT_W-1:0] free,
	output logic                          out_wr,
	output itar_pkg::out_item_t           out_item
);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SIGN = 4'b0100,
		ST_EMIT = 4'b1000
	} back_state_t;

	back_state_t                        state_q;
	logic [itar_pkg::PAD_W-1:0]         quot_q;
	logic [itar_pkg::REM_W-1:0]         rem_q;
	logic [itar_pkg::RADIX_W-1:0]       radix_q;
	logic                               neg_q;
	logic [itar_pkg::STEP_W-1:0]        step_q;
	logic [itar_pkg::CNT_W-1:0]         count_q;
	logic [itar_pkg::ADDR_W-1:0]        rd_ptr_q;
	logic [itar_pkg::RADIX_W-1:0]       digit_mem [itar_pkg::VALUE_WIDTH];

	logic [itar_pkg::PAD_W-1:0]         quot_c;
	logic [itar_pkg::REM_W-1:0]         rem_c;
	logic                               digit_done;
	logic                               conv_done;
	logic [itar_pkg::CNT_W-1:0]         count_inc;
	logic                               room;
	logic                               issue_sign;
	logic                               issue_digit;

	logic                               vld_s1;
	logic                               sign_s1;
	logic                               last_s1;
	logic [itar_pkg::RADIX_W-1:0]       digit_s1;

	// One slice of restoring division: DIV_BITS quotient bits per cycle
	always_comb begin
		rem_c  = rem_q;
		quot_c = quot_q;
		for (int i = 0; i < itar_pkg::DIV_BITS; i++) begin
			rem_c  = {rem_c[itar_pkg::REM_W-2:0], quot_c[itar_pkg::PAD_W-1]};
			quot_c = {quot_c[itar_pkg::PAD_W-2:0], 1'b0};
			if (rem_c >= itar_pkg::REM_W'(radix_q)) begin
				rem_c     = rem_c - itar_pkg::REM_W'(radix_q);
				quot_c[0] = 1'b1;
			end
		end
	end

	assign digit_done = (state_q == ST_DIV) &&
		(step_q == itar_pkg::STEP_W'(itar_pkg::DIV_CYCLES - 1));
	assign count_inc  = count_q + 1'b1;
	assign conv_done  = (quot_c == '0) ||
		(count_inc == itar_pkg::CNT_W'(itar_pkg::VALUE_WIDTH));

	// Credit check: keep one slot free for each character still in flight
	assign room        = (free > itar_pkg::OQ_CNT_W'(vld_s1));
	assign issue_sign  = (state_q == ST_SIGN) && room;
	assign issue_digit = (state_q == ST_EMIT) && room;
	assign work_rdy    = (state_q == ST_IDLE);

	always_ff @(posedge clk) begin
		if (digit_done) begin
			digit_mem[count_q[itar_pkg::ADDR_W-1:0]] <= rem_c[itar_pkg::RADIX_W-1:0];
		end
		if (issue_digit) begin
			digit_s1 <= digit_mem[rd_ptr_q];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				quot_q  <= itar_pkg::PAD_W'(work.magnitude);
				rem_q   <= '0;
				radix_q <= work.radix;
				neg_q   <= work.negative;
			end
			ST_DIV: begin
				if (digit_done) begin
					quot_q <= quot_c;
					rem_q  <= '0;
				end else begin
					quot_q <= quot_c;
					rem_q  <= rem_c;
				end
			end
			default: begin
				quot_q <= quot_q;
			end
		endcase
		if (issue_sign || issue_digit) begin
			sign_s1 <= issue_sign;
			last_s1 <= issue_digit && (rd_ptr_q == '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= ST_IDLE;
			step_q   <= '0;
			count_q  <= '0;
			rd_ptr_q <= '0;
			vld_s1   <= 1'b0;
		end else begin
			vld_s1 <= issue_sign || issue_digit;
			case (state_q)
				ST_IDLE: begin
					step_q  <= '0;
					count_q <= '0;
					if (work_vld) begin
						state_q <= ST_DIV;
					end
				end
				ST_DIV: begin
					if (digit_done) begin
						step_q  <= '0;
						count_q <= count_inc;
						if (conv_done) begin
							// Most significant digit sits at the last written slot
							rd_ptr_q <= count_q[itar_pkg::ADDR_W-1:0];
							state_q  <= neg_q ? ST_SIGN : ST_EMIT;
						end
					end else begin
						step_q <= step_q + 1'b1;
					end
				end
				ST_SIGN: begin
					if (issue_sign) begin
						state_q <= ST_EMIT;
					end
				end
				ST_EMIT: begin
					if (issue_digit) begin
						if (rd_ptr_q == '0) begin
							state_q <= ST_IDLE;
						end else begin
							rd_ptr_q <= rd_ptr_q - 1'b1;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign out_wr             = vld_s1;
	assign out_item.character = sign_s1 ? itar_pkg::CH_MINUS : itar_pkg::digit_ascii(digit_s1);
	assign out_item.last      = last_s1;

`ifndef SYNTHESIS
	a_emit_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT) |-> (itar_pkg::CNT_W'(rd_ptr_q) < count_q))
		else $error("digit read beyond produced digits");
	a_sign_not_last: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s1 |-> !(sign_s1 && last_s1))
		else $error("sign marked as final character");
`endif

endmodule

// File: design/itar_outq.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itar_outq: result queue
// Holds issued characters until the receiver pops them; reports free slots.
// ----------------------------------------------------------------------------
module itar_outq (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr,
	input  itar_pkg::out_item_t           wr_item,
	output logic [itar_pkg::OQ_CNT_W-1:0] free,
	output logic                          empty,
	input  logic                          pop,
	output itar_pkg::out_item_t           result
);

	itar_pkg::out_item_t             entry_q [itar_pkg::OQ_DEPTH];
	logic [itar_pkg::OQ_PTR_W-1:0]   wr_ptr_q;
	logic [itar_pkg::OQ_PTR_W-1:0]   rd_ptr_q;
	logic [itar_pkg::OQ_CNT_W-1:0]   count_q;
	logic                            rd;

	assign empty  = (count_q == '0);
	assign free   = itar_pkg::OQ_CNT_W'(itar_pkg::OQ_DEPTH) - count_q;
	assign result = entry_q[rd_ptr_q];
	assign rd     = pop && !empty;

	always_ff @(posedge clk) begin
		if (wr) begin
			entry_q[wr_ptr_q] <= wr_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (wr) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (rd) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({wr, rd})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

`ifndef SYNTHESIS
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		wr |-> (count_q != itar_pkg::OQ_CNT_W'(itar_pkg::OQ_DEPTH)))
		else $error("character written into a full result queue");
`endif

endmodule

// File: design/integer_to_ascii_radix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix: signed integer to ASCII text in base 2 to 36
// Front classifies, back divides and issues characters, queue holds results.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive request (value, radix) and raise push; a transfer
//   happens on a clock edge with push high and full low. The front takes up
//   to two items ahead of the converter.
//   Result queue: while empty is low, result holds the oldest character;
//   a transfer happens on an edge with pop high and empty low. The text runs
//   most significant first, '-' leads a negative value, last marks the end.
//   Timing: the shared divider resolves 8 quotient bits per cycle; all
//   digits of an item are found before its first character is issued.
//   Items are converted one at a time; characters leave at one per
//   cycle while the result queue has room.
//   Reset (arst_n low) empties both queues and returns the converter to idle.
//   When the receiver stalls, the result queue fills and character issue
//   holds; the front still takes items until its own queue is full.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                push,
	output logic                full,
	input  itar_pkg::in_item_t  request,
	output logic                empty,
	input  logic                pop,
	output itar_pkg::out_item_t result
);

	logic                          work_vld;
	logic                          work_rdy;
	itar_pkg::work_t               work;
	logic [itar_pkg::OQ_CNT_W-1:0] free;
	logic                          out_wr;
	itar_pkg::out_item_t           out_item;

	// Accept and classify items, buffer them ahead of the converter
	itar_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.full     (full),
		.request  (request),
		.work_vld (work_vld),
		.work_rdy (work_rdy),
		.work     (work)
	);

	// Convert one item at a time; issue only with credit in the result queue
	itar_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.work_vld (work_vld),
		.work_rdy (work_rdy),
		.work     (work),
		.free     (free),
		.out_wr   (out_wr),
		.out_item (out_item)
	);

	// Hold characters until the receiver pops them
	itar_outq u_outq (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (out_wr),
		.wr_item (out_item),
		.free    (free),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

endmodule

// File: tb/tb_integer_to_ascii_radix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_integer_to_ascii_radix: self-checking bench for the radix text converter
// Pushes signed integers with a base, pops the character runs and checks each
// character and its last mark against a local model of the conversion. A
// short table of corner values comes first, then random traffic with random
// gaps on both queues and one long receiver hold-off that backs up the input.
// ----------------------------------------------------------------------------
module tb_integer_to_ascii_radix;

	localparam int CLK_HALF     = 5;
	localparam int RESET_CYCLES = 9;
	localparam int DIR_ROWS     = 23;
	localparam int RAND_ITEMS   = 137;
	localparam int IDLE_PCT     = 29;
	// Receiver hold-off: far longer than the input side can buffer
	localparam int HOLD_CYCLES  = 400;
	// Worst run is 33 characters; the drain must outlast it
	localparam int DRAIN_CYCLES = 250;
	// Cycles with no transfer on either queue before the run is abandoned
	localparam int STALL_LIMIT  = 5000;

	logic                clk;
	logic                arst_n;
	logic                push;
	logic                full;
	itar_pkg::in_item_t  request;
	logic                empty;
	logic                pop;
	itar_pkg::out_item_t result;

	// Characters still owed by the block, oldest first
	itar_pkg::out_item_t chars_due[$];
	int                  errors = 0;
	int                  stall_cycles;
	int                  idle_pct;
	logic                hold_go;

	integer_to_ascii_radix uut (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.full    (full),
		.request (request),
		.empty   (empty),
		.pop     (pop),
		.result  (result)
	);

	initial begin
		clk = 1'b0;
	end

	always #CLK_HALF clk = ~clk;

	function automatic itar_pkg::in_item_t make_item(input int value, input int radix);
		itar_pkg::in_item_t item;
		item.value = itar_pkg::VALUE_WIDTH'(value);
		item.radix = itar_pkg::RADIX_W'(radix);
		return item;
	endfunction

	// Map one digit value to its ASCII code: decimal digits, then letters
	function automatic logic [itar_pkg::CHAR_W-1:0] digit_glyph(
			input logic [itar_pkg::RADIX_W-1:0] digit);
		if (itar_pkg::CHAR_W'(digit) < itar_pkg::DECIMAL_LIMIT) begin
			return itar_pkg::CH_ZERO + itar_pkg::CHAR_W'(digit);
		end
		return itar_pkg::CH_UPPER_A + itar_pkg::CHAR_W'(digit) - itar_pkg::DECIMAL_LIMIT;
	endfunction

	// Append the text of one item to the owed characters: clamp the base,
	// take the magnitude as unsigned so the most negative value survives,
	// split digits least significant first, then emit sign and digits
	// most significant first with last on the final digit.
	task automatic queue_text_of(input itar_pkg::in_item_t item);
		logic [itar_pkg::VALUE_WIDTH-1:0] mag;
		logic [itar_pkg::RADIX_W-1:0]     base;
		logic [itar_pkg::RADIX_W-1:0]     digits [itar_pkg::VALUE_WIDTH];
		logic                             neg;
		itar_pkg::out_item_t              ch;
		int                               n;
		base = item.radix;
		if (base < itar_pkg::MIN_RADIX) begin
			base = itar_pkg::MIN_RADIX;
		end
		if (base > itar_pkg::MAX_RADIX) begin
			base = itar_pkg::MAX_RADIX;
		end
		neg = item.value[itar_pkg::VALUE_WIDTH-1];
		mag = neg ? itar_pkg::VALUE_WIDTH'(~item.value + 1)
			: itar_pkg::VALUE_WIDTH'(item.value);
		n = 0;
		do begin
			digits[n] = itar_pkg::RADIX_W'(mag % itar_pkg::VALUE_WIDTH'(base));
			mag = mag / itar_pkg::VALUE_WIDTH'(base);
			n++;
		end while (mag != 0 && n < itar_pkg::VALUE_WIDTH);
		if (neg) begin
			ch.character = itar_pkg::CH_MINUS;
			ch.last = 1'b0;
			chars_due.push_back(ch);
		end
		for (int k = n - 1; k >= 0; k--) begin
			ch.character = digit_glyph(digits[k]);
			ch.last = (k == 0);
			chars_due.push_back(ch);
		end
	endtask

	// Record what an accepted item owes: the typed text when the table row
	// gives one, otherwise the model's answer.
	task automatic note_transfer(input itar_pkg::in_item_t item, input string text);
		itar_pkg::out_item_t ch;
		if (text.len() == 0) begin
			queue_text_of(item);
		end else begin
			for (int i = 0; i < text.len(); i++) begin
				ch.character = itar_pkg::CHAR_W'(text[i]);
				ch.last = (i == text.len() - 1);
				chars_due.push_back(ch);
			end
		end
	endtask

	// Offer one item after a random number of idle cycles and hold it until
	// the block takes it. full is sampled before this edge's updates land.
	task automatic offer(input itar_pkg::in_item_t item, input string text);
		while ($urandom_range(0, 99) < idle_pct) begin
			push <= 1'b0;
			@(posedge clk);
		end
		push <= 1'b1;
		request <= item;
		do begin
			@(posedge clk);
		end while (!(push && !full));
		note_transfer(item, text);
	endtask

	function automatic itar_pkg::in_item_t random_item();
		int value;
		int radix;
		int pick;
		pick = $urandom_range(0, 9);
		if (pick < 5) begin
			value = $urandom;
		end else if (pick < 7) begin
			// small magnitudes give short runs and exercise the sign path
			value = $urandom_range(0, 1000);
			if ($urandom_range(0, 1)) begin
				value = -value;
			end
		end else if (pick < 9) begin
			// corner values: zero, one, minus one, both extremes
			case ($urandom_range(0, 4))
				0: begin
					value = 0;
				end
				1: begin
					value = 1;
				end
				2: begin
					value = -1;
				end
				3: begin
					value = 32'sh7FFFFFFF;
				end
				default: begin
					value = 32'sh80000000;
				end
			endcase
		end else begin
			value = $urandom & (32'hFFFFFFFF >> $urandom_range(0, 31));
		end
		pick = $urandom_range(0, 19);
		if (pick < 16) begin
			radix = $urandom_range(2, 36);
		end else if (pick < 18) begin
			// any code the port can carry, out of range ones included
			radix = $urandom_range(0, 63);
		end else begin
			radix = int'(itar_pkg::MIN_RADIX);
		end
		return make_item(value, radix);
	endfunction

	// Compare one popped character with the oldest one owed
	task automatic check_char(input itar_pkg::out_item_t got);
		itar_pkg::out_item_t want;
		if (chars_due.size() == 0) begin
			$error("character 0x%0h with no character owed", got.character);
			errors++;
		end else begin
			want = chars_due.pop_front();
			if (got.character !== want.character) begin
				$error("character: expected 0x%0h, actual 0x%0h",
					want.character, got.character);
				errors++;
			end
			if (got.last !== want.last) begin
				$error("last: expected %0b, actual %0b", want.last, got.last);
				errors++;
			end
		end
	endtask

	// Receiver: check every transfer, then pick pop for the next edge.
	// Hold pop low for one long stretch once the sender asks for it.
	initial begin : drain
		int hold_left;
		bit hold_done;
		hold_left = 0;
		hold_done = 0;
		pop = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			@(posedge clk);
			if (pop && !empty) begin
				check_char(result);
			end
			if (hold_go && !hold_done) begin
				hold_left = HOLD_CYCLES;
				hold_done = 1;
			end
			if (hold_left > 0) begin
				hold_left--;
				pop <= 1'b0;
			end else begin
				pop <= ($urandom_range(0, 99) >= idle_pct);
			end
		end
	end

	// Watchdog: abandon the run when neither queue moves for too long
	always @(posedge clk) begin
		if (!arst_n) begin
			stall_cycles <= 0;
		end else begin
			if ((push && !full) || (pop && !empty)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= STALL_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	initial begin : stimulus
		itar_pkg::in_item_t dir_item [DIR_ROWS];
		string              dir_text [DIR_ROWS];
		idle_pct = IDLE_PCT;
		hold_go = 1'b0;
		arst_n = 1'b0;
		push = 1'b0;
		request = '0;

		// Corner table; an empty text means the model supplies the answer
		dir_item[0]  = make_item(0, 10);                dir_text[0]  = "0";
		dir_item[1]  = make_item(1, 10);                dir_text[1]  = "1";
		dir_item[2]  = make_item(-1, 10);               dir_text[2]  = "-1";
		dir_item[3]  = make_item(32'sh7FFFFFFF, 10);    dir_text[3]  = "2147483647";
		dir_item[4]  = make_item(32'sh80000000, 10);    dir_text[4]  = "-2147483648";
		dir_item[5]  = make_item(32'sh7FFFFFFF, 16);    dir_text[5]  = "7FFFFFFF";
		dir_item[6]  = make_item(32'sh80000000, 16);    dir_text[6]  = "-80000000";
		dir_item[7]  = make_item(-1, 16);               dir_text[7]  = "-1";
		dir_item[8]  = make_item(32'sh7FFFFFFF, 36);    dir_text[8]  = "ZIK0ZJ";
		dir_item[9]  = make_item(60466175, 36);         dir_text[9]  = "ZZZZZ";
		// digit ten must be a letter, not the character after '9'
		dir_item[10] = make_item(10, 11);               dir_text[10] = "A";
		dir_item[11] = make_item(9, 10);                dir_text[11] = "9";
		dir_item[12] = make_item(35, 36);               dir_text[12] = "Z";
		// bases below two behave as two, above thirty-six as thirty-six
		dir_item[13] = make_item(5, 0);                 dir_text[13] = "101";
		dir_item[14] = make_item(5, 1);                 dir_text[14] = "101";
		dir_item[15] = make_item(35, 37);               dir_text[15] = "Z";
		dir_item[16] = make_item(35, 63);               dir_text[16] = "Z";
		dir_item[17] = make_item(0, 2);                 dir_text[17] = "0";
		dir_item[18] = make_item(0, 36);                dir_text[18] = "0";
		// longest runs: full binary width with and without sign, then bases 13 and 8
		dir_item[19] = make_item(32'sh7FFFFFFF, 2);     dir_text[19] = "";
		dir_item[20] = make_item(32'sh80000000, 2);     dir_text[20] = "";
		dir_item[21] = make_item(-987654321, 13);       dir_text[21] = "";
		dir_item[22] = make_item(32'sh12345678, 8);     dir_text[22] = "";

		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int i = 0; i < DIR_ROWS; i++) begin
			offer(dir_item[i], dir_text[i]);
		end

		// Random traffic: back up the input early, then run a gap-free stretch
		hold_go <= 1'b1;
		for (int i = 0; i < RAND_ITEMS; i++) begin
			if (i == 60) begin
				idle_pct <= 0;
			end else if (i == 110) begin
				idle_pct <= IDLE_PCT;
			end
			offer(random_item(), "");
		end
		push <= 1'b0;

		// Drain: wait for every owed character, then watch for strays
		while (chars_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && chars_due.size() == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
